FILE: hw/rtl/mflg_pkg.sv
`default_nettype none
package mflg_pkg;

    localparam int MAX_VERTICES_DEF = 256;
    localparam int MAX_ARCS_DEF     = 8192;

    localparam int CMD_W   = 2;
    localparam int VTX_W   = 8;
    localparam int CAP_W   = 32;
    localparam int FLOW_W  = 48;
    localparam int STAT_W  = 2;
    localparam int CFG_W   = 9;

    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ADD   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SOLVE = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic [VTX_W-1:0] from_vertex;
        logic [VTX_W-1:0] to_vertex;
        logic [CAP_W-1:0] capacity;
    } in_item_t;

    typedef struct packed {
        logic [FLOW_W-1:0] max_flow;
        logic [STAT_W-1:0] status;
    } out_item_t;

    typedef struct packed {
        logic ready;
        logic done;
    } eng_stat_t;

endpackage
`default_nettype wire

FILE: hw/rtl/max_flow_level_graph_top.sv
// channel | dir | handshake         | payload
// req     | in  | req_valid/stall   | command, from_vertex, to_vertex, capacity
// rsp     | out | rsp_valid/stall   | max_flow, status
// cfg     | in  | cfg_valid/ready   | vertex_count
// Solve time is data dependent: each phase resets the levels, runs a level search
// from the sink over a queue, scanning the arcs of each vertex taken from it, then
// walks from vertex 0 probing arcs, and for each path found takes the bottleneck and
// updates the residuals along it; the arc memories give one read a cycle each.
// After reset a clearing pass over the list heads runs with req stalled. A finished
// result sits in the rsp register while the next beat is taken.
`default_nettype none
module max_flow_level_graph_top #(
    parameter int MAX_VERTICES = mflg_pkg::MAX_VERTICES_DEF,
    parameter int MAX_ARCS     = mflg_pkg::MAX_ARCS_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       req_valid,
    output logic                            req_stall,
    input  wire mflg_pkg::in_item_t         req,
    output logic                            rsp_valid,
    input  wire logic                       rsp_stall,
    output mflg_pkg::out_item_t             rsp,
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic [mflg_pkg::CFG_W-1:0] cfg_data
);
    import mflg_pkg::*;

    logic [CFG_W-1:0] vertex_count_reg;
    logic             rsp_valid_reg, rsp_valid_next;
    out_item_t        rsp_reg;
    eng_stat_t        stat;
    out_item_t        result;
    logic             take;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vertex_count_reg <= CFG_W'(2);
        end
        else if (cfg_valid && cfg_ready)
        begin
            vertex_count_reg <= cfg_data;
        end
    end

    mflg_engine #(
        .MAX_VERTICES (MAX_VERTICES),
        .MAX_ARCS     (MAX_ARCS)
    ) u_engine (
        .clk          (clk),
        .rst_n        (rst_n),
        .vertex_count (vertex_count_reg),
        .start        (req_valid && !req_stall),
        .item         (req),
        .ack          (take),
        .stat         (stat),
        .result       (result)
    );

    assign req_stall = !stat.ready;
    assign take      = stat.done && (!rsp_valid_reg || !rsp_stall);

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (take)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            rsp_reg <= result;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule
`default_nettype wire

FILE: hw/rtl/mflg_engine.sv
`default_nettype none
module mflg_engine #(
    parameter int MAX_VERTICES = mflg_pkg::MAX_VERTICES_DEF,
    parameter int MAX_ARCS     = mflg_pkg::MAX_ARCS_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic [mflg_pkg::CFG_W-1:0] vertex_count,
    input  wire logic                       start,
    input  wire mflg_pkg::in_item_t         item,
    input  wire logic                       ack,
    output mflg_pkg::eng_stat_t             stat,
    output mflg_pkg::out_item_t             result
);
    import mflg_pkg::*;

    localparam int VIW  = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int NW   = $clog2(MAX_VERTICES + 1);
    localparam int AIW  = (MAX_ARCS > 1) ? $clog2(MAX_ARCS) : 1;
    localparam int ACW  = $clog2(MAX_ARCS + 1);
    localparam int LKW  = AIW + 1;
    localparam int LW   = VIW + 2;
    localparam int DL_W = VTX_W + LKW;

    localparam logic [LKW-1:0] LINK_NULL = {1'b1, {AIW{1'b0}}};
    localparam logic [LW-1:0]  LVL_NONE  = {LW{1'b1}};
    localparam logic [LW-1:0]  LVL_DEAD  = LVL_NONE - LW'(1);

    localparam int SW = 6;
    localparam logic [SW-1:0] S_CLR     = 6'd0;
    localparam logic [SW-1:0] S_IDLE    = 6'd1;
    localparam logic [SW-1:0] S_ADD1    = 6'd2;
    localparam logic [SW-1:0] S_ADD2    = 6'd3;
    localparam logic [SW-1:0] S_ADD3    = 6'd4;
    localparam logic [SW-1:0] S_ADD4    = 6'd5;
    localparam logic [SW-1:0] S_DONE    = 6'd6;
    localparam logic [SW-1:0] S_LV_INIT = 6'd7;
    localparam logic [SW-1:0] S_LV_SEED = 6'd8;
    localparam logic [SW-1:0] S_BQ      = 6'd9;
    localparam logic [SW-1:0] S_BQ_U    = 6'd10;
    localparam logic [SW-1:0] S_BQ_H    = 6'd11;
    localparam logic [SW-1:0] S_BQ_A    = 6'd12;
    localparam logic [SW-1:0] S_BQ_D    = 6'd13;
    localparam logic [SW-1:0] S_PH_CHK  = 6'd14;
    localparam logic [SW-1:0] S_W_START = 6'd15;
    localparam logic [SW-1:0] S_W_LOAD  = 6'd16;
    localparam logic [SW-1:0] S_W_TOP   = 6'd17;
    localparam logic [SW-1:0] S_W_A     = 6'd18;
    localparam logic [SW-1:0] S_W_D     = 6'd19;
    localparam logic [SW-1:0] S_W_HEAD  = 6'd20;
    localparam logic [SW-1:0] S_W_DEAD  = 6'd21;
    localparam logic [SW-1:0] S_W_POP   = 6'd22;
    localparam logic [SW-1:0] S_W_POP2  = 6'd23;
    localparam logic [SW-1:0] S_W_POP3  = 6'd24;
    localparam logic [SW-1:0] S_W_POP4  = 6'd25;
    localparam logic [SW-1:0] S_BN_RD   = 6'd26;
    localparam logic [SW-1:0] S_BN_S    = 6'd27;
    localparam logic [SW-1:0] S_BN_R    = 6'd28;
    localparam logic [SW-1:0] S_UP_RD   = 6'd29;
    localparam logic [SW-1:0] S_UP_S    = 6'd30;
    localparam logic [SW-1:0] S_UP_A    = 6'd31;
    localparam logic [SW-1:0] S_UP_B    = 6'd32;

    // memories
    logic [CAP_W-1:0] res_mem   [MAX_ARCS];
    logic [DL_W-1:0]  dl_mem    [MAX_ARCS];
    logic [LKW-1:0]   head_mem  [MAX_VERTICES];
    logic [LW-1:0]    lvl_mem   [MAX_VERTICES];
    logic [VIW-1:0]   queue_mem [MAX_VERTICES];
    logic [AIW-1:0]   stack_mem [MAX_VERTICES];

    logic             res_we, res_re, dl_we, dl_re, head_we, head_re;
    logic             lvl_we, lvl_re, queue_we, queue_re, stack_we, stack_re;
    logic [AIW-1:0]   res_wa, res_ra, dl_wa, dl_ra, stack_wd, stack_q;
    logic [VIW-1:0]   head_wa, head_ra, lvl_wa, lvl_ra, queue_wa, queue_ra;
    logic [VIW-1:0]   stack_wa, stack_ra, queue_wd, queue_q;
    logic [CAP_W-1:0] res_wd, res_q;
    logic [DL_W-1:0]  dl_wd, dl_q;
    logic [LKW-1:0]   head_wd, head_q;
    logic [LW-1:0]    lvl_wd, lvl_q;

    always_ff @(posedge clk)
    begin
        if (res_we)
        begin
            res_mem[res_wa] <= res_wd;
        end
        if (res_re)
        begin
            res_q <= res_mem[res_ra];
        end
    end

    always_ff @(posedge clk)
    begin
        if (dl_we)
        begin
            dl_mem[dl_wa] <= dl_wd;
        end
        if (dl_re)
        begin
            dl_q <= dl_mem[dl_ra];
        end
    end

    always_ff @(posedge clk)
    begin
        if (head_we)
        begin
            head_mem[head_wa] <= head_wd;
        end
        if (head_re)
        begin
            head_q <= head_mem[head_ra];
        end
    end

    always_ff @(posedge clk)
    begin
        if (lvl_we)
        begin
            lvl_mem[lvl_wa] <= lvl_wd;
        end
        if (lvl_re)
        begin
            lvl_q <= lvl_mem[lvl_ra];
        end
    end

    always_ff @(posedge clk)
    begin
        if (queue_we)
        begin
            queue_mem[queue_wa] <= queue_wd;
        end
        if (queue_re)
        begin
            queue_q <= queue_mem[queue_ra];
        end
    end

    always_ff @(posedge clk)
    begin
        if (stack_we)
        begin
            stack_mem[stack_wa] <= stack_wd;
        end
        if (stack_re)
        begin
            stack_q <= stack_mem[stack_ra];
        end
    end

    // control registers
    logic [SW-1:0]     state_reg, state_next;
    logic [NW-1:0]     idx_reg, idx_next;
    logic              pend_reg, pend_next;
    logic [ACW-1:0]    arc_count_reg, arc_count_next;
    logic [FLOW_W-1:0] total_reg, total_next;
    logic [STAT_W-1:0] status_reg, status_next;
    logic [NW-1:0]     rd_reg, rd_next, wr_reg, wr_next;
    logic [VIW-1:0]    depth_reg, depth_next, k_reg, k_next;
    // datapath registers
    in_item_t          item_reg, item_next;
    logic [VIW-1:0]    v_reg, v_next, d_reg, d_next;
    logic [LKW-1:0]    cur_reg, cur_next;
    logic [LW-1:0]     vlev_reg, vlev_next;
    logic [AIW-1:0]    arc_reg, arc_next;
    logic [CAP_W-1:0]  b_reg, b_next;

    logic [NW-1:0]     n_eff;
    logic [VIW-1:0]    sink;
    logic [AIW-1:0]    arc_lo, arc_hi;
    logic [VTX_W-1:0]  dl_dest;
    logic [LKW-1:0]    dl_link;
    logic              dest_ok;
    logic [FLOW_W:0]   flow_sum;

    always_comb
    begin
        if (vertex_count < CFG_W'(2))
        begin
            n_eff = NW'(2);
        end
        else if (32'(vertex_count) > 32'(MAX_VERTICES))
        begin
            n_eff = NW'(MAX_VERTICES);
        end
        else
        begin
            n_eff = NW'(vertex_count);
        end
    end

    assign sink     = VIW'(n_eff - NW'(1));
    assign arc_lo   = AIW'(arc_count_reg);
    assign arc_hi   = arc_lo | AIW'(1);
    assign dl_dest  = dl_q[DL_W-1 -: VTX_W];
    assign dl_link  = dl_q[LKW-1:0];
    assign dest_ok  = 32'(dl_dest) < 32'(n_eff);
    assign flow_sum = {1'b0, total_reg} + (FLOW_W + 1)'(b_reg);

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        pend_next      = pend_reg;
        arc_count_next = arc_count_reg;
        total_next     = total_reg;
        status_next    = status_reg;
        rd_next        = rd_reg;
        wr_next        = wr_reg;
        depth_next     = depth_reg;
        k_next         = k_reg;
        item_next      = item_reg;
        v_next         = v_reg;
        d_next         = d_reg;
        cur_next       = cur_reg;
        vlev_next      = vlev_reg;
        arc_next       = arc_reg;
        b_next         = b_reg;

        res_we = 1'b0; res_re = 1'b0; res_wa = '0; res_ra = '0; res_wd = '0;
        dl_we = 1'b0; dl_re = 1'b0; dl_wa = '0; dl_ra = '0; dl_wd = '0;
        head_we = 1'b0; head_re = 1'b0; head_wa = '0; head_ra = '0; head_wd = '0;
        lvl_we = 1'b0; lvl_re = 1'b0; lvl_wa = '0; lvl_ra = '0; lvl_wd = '0;
        queue_we = 1'b0; queue_re = 1'b0; queue_wa = '0; queue_ra = '0; queue_wd = '0;
        stack_we = 1'b0; stack_re = 1'b0; stack_wa = '0; stack_ra = '0; stack_wd = '0;

        unique case (state_reg)
            S_CLR:
            begin
                head_we  = 1'b1;
                head_wa  = VIW'(idx_reg);
                head_wd  = LINK_NULL;
                idx_next = idx_reg + NW'(1);
                if (idx_reg == NW'(MAX_VERTICES - 1))
                begin
                    arc_count_next = '0;
                    state_next     = pend_reg ? S_DONE : S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    item_next   = item;
                    total_next  = '0;
                    status_next = ST_OK;
                    idx_next    = '0;
                    unique case (item.command)
                        CMD_CLEAR:
                        begin
                            pend_next  = 1'b1;
                            state_next = S_CLR;
                        end
                        CMD_ADD:
                        begin
                            if (32'(item.from_vertex) >= 32'(n_eff) ||
                                32'(item.to_vertex) >= 32'(n_eff))
                            begin
                                status_next = ST_RANGE;
                                state_next  = S_DONE;
                            end
                            else if (32'(arc_count_reg) + 32'd2 > 32'(MAX_ARCS))
                            begin
                                status_next = ST_FULL;
                                state_next  = S_DONE;
                            end
                            else
                            begin
                                state_next = S_ADD1;
                            end
                        end
                        CMD_SOLVE:
                        begin
                            state_next = S_LV_INIT;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_ADD1:
            begin
                head_re    = 1'b1;
                head_ra    = VIW'(item_reg.from_vertex);
                state_next = S_ADD2;
            end
            S_ADD2:
            begin
                dl_we      = 1'b1;
                dl_wa      = arc_lo;
                dl_wd      = {item_reg.to_vertex, head_q};
                res_we     = 1'b1;
                res_wa     = arc_lo;
                res_wd     = item_reg.capacity;
                head_we    = 1'b1;
                head_wa    = VIW'(item_reg.from_vertex);
                head_wd    = {1'b0, arc_lo};
                state_next = S_ADD3;
            end
            S_ADD3:
            begin
                // read after the first push so a self loop sees the new head
                head_re    = 1'b1;
                head_ra    = VIW'(item_reg.to_vertex);
                state_next = S_ADD4;
            end
            S_ADD4:
            begin
                dl_we          = 1'b1;
                dl_wa          = arc_hi;
                dl_wd          = {item_reg.from_vertex, head_q};
                res_we         = 1'b1;
                res_wa         = arc_hi;
                res_wd         = '0;
                head_we        = 1'b1;
                head_wa        = VIW'(item_reg.to_vertex);
                head_wd        = {1'b0, arc_hi};
                arc_count_next = arc_count_reg + ACW'(2);
                state_next     = S_DONE;
            end
            S_DONE:
            begin
                pend_next = 1'b0;
                if (ack)
                begin
                    state_next = S_IDLE;
                end
            end
            S_LV_INIT:
            begin
                lvl_we   = 1'b1;
                lvl_wa   = VIW'(idx_reg);
                lvl_wd   = LVL_NONE;
                idx_next = idx_reg + NW'(1);
                if (idx_reg == n_eff - NW'(1))
                begin
                    state_next = S_LV_SEED;
                end
            end
            S_LV_SEED:
            begin
                lvl_we     = 1'b1;
                lvl_wa     = sink;
                lvl_wd     = '0;
                queue_we   = 1'b1;
                queue_wa   = '0;
                queue_wd   = sink;
                rd_next    = '0;
                wr_next    = NW'(1);
                state_next = S_BQ;
            end
            S_BQ:
            begin
                if (rd_reg == wr_reg)
                begin
                    lvl_re     = 1'b1;
                    lvl_ra     = '0;
                    state_next = S_PH_CHK;
                end
                else
                begin
                    queue_re   = 1'b1;
                    queue_ra   = VIW'(rd_reg);
                    rd_next    = rd_reg + NW'(1);
                    state_next = S_BQ_U;
                end
            end
            S_BQ_U:
            begin
                head_re    = 1'b1;
                head_ra    = queue_q;
                lvl_re     = 1'b1;
                lvl_ra     = queue_q;
                state_next = S_BQ_H;
            end
            S_BQ_H:
            begin
                vlev_next = lvl_q;
                cur_next  = head_q;
                if (head_q[LKW-1])
                begin
                    state_next = S_BQ;
                end
                else
                begin
                    dl_re      = 1'b1;
                    dl_ra      = head_q[AIW-1:0];
                    res_re     = 1'b1;
                    res_ra     = head_q[AIW-1:0] ^ AIW'(1);
                    state_next = S_BQ_A;
                end
            end
            S_BQ_A:
            begin
                if (dest_ok)
                begin
                    d_next     = VIW'(dl_dest);
                    lvl_re     = 1'b1;
                    lvl_ra     = VIW'(dl_dest);
                    state_next = S_BQ_D;
                end
                else if (dl_link[LKW-1])
                begin
                    state_next = S_BQ;
                end
                else
                begin
                    dl_re      = 1'b1;
                    dl_ra      = dl_link[AIW-1:0];
                    res_re     = 1'b1;
                    res_ra     = dl_link[AIW-1:0] ^ AIW'(1);
                    state_next = S_BQ_A;
                end
            end
            S_BQ_D:
            begin
                if (lvl_q == LVL_NONE && res_q != '0)
                begin
                    lvl_we   = 1'b1;
                    lvl_wa   = d_reg;
                    lvl_wd   = vlev_reg + LW'(1);
                    queue_we = 1'b1;
                    queue_wa = VIW'(wr_reg);
                    queue_wd = d_reg;
                    wr_next  = wr_reg + NW'(1);
                end
                if (dl_link[LKW-1])
                begin
                    state_next = S_BQ;
                end
                else
                begin
                    dl_re      = 1'b1;
                    dl_ra      = dl_link[AIW-1:0];
                    res_re     = 1'b1;
                    res_ra     = dl_link[AIW-1:0] ^ AIW'(1);
                    state_next = S_BQ_A;
                end
            end
            S_PH_CHK:
            begin
                state_next = (lvl_q == LVL_NONE) ? S_DONE : S_W_START;
            end
            S_W_START:
            begin
                v_next     = '0;
                depth_next = '0;
                head_re    = 1'b1;
                head_ra    = '0;
                lvl_re     = 1'b1;
                lvl_ra     = '0;
                state_next = S_W_LOAD;
            end
            S_W_LOAD:
            begin
                cur_next   = head_q;
                vlev_next  = lvl_q;
                state_next = S_W_TOP;
            end
            S_W_TOP:
            begin
                if (v_reg == sink)
                begin
                    k_next     = '0;
                    b_next     = '1;
                    state_next = S_BN_RD;
                end
                else if (cur_reg[LKW-1])
                begin
                    state_next = S_W_DEAD;
                end
                else
                begin
                    dl_re      = 1'b1;
                    dl_ra      = cur_reg[AIW-1:0];
                    res_re     = 1'b1;
                    res_ra     = cur_reg[AIW-1:0];
                    state_next = S_W_A;
                end
            end
            S_W_A:
            begin
                if (dest_ok)
                begin
                    d_next     = VIW'(dl_dest);
                    lvl_re     = 1'b1;
                    lvl_ra     = VIW'(dl_dest);
                    state_next = S_W_D;
                end
                else
                begin
                    cur_next   = dl_link;
                    state_next = S_W_TOP;
                end
            end
            S_W_D:
            begin
                if (lvl_q == vlev_reg - LW'(1) && res_q != '0)
                begin
                    stack_we   = 1'b1;
                    stack_wa   = depth_reg;
                    stack_wd   = cur_reg[AIW-1:0];
                    depth_next = depth_reg + VIW'(1);
                    v_next     = d_reg;
                    vlev_next  = lvl_q;
                    head_re    = 1'b1;
                    head_ra    = d_reg;
                    state_next = S_W_HEAD;
                end
                else
                begin
                    cur_next   = dl_link;
                    state_next = S_W_TOP;
                end
            end
            S_W_HEAD:
            begin
                cur_next   = head_q;
                state_next = S_W_TOP;
            end
            S_W_DEAD:
            begin
                lvl_we = 1'b1;
                lvl_wa = v_reg;
                lvl_wd = LVL_DEAD;
                if (depth_reg == '0)
                begin
                    // walk found nothing: next phase
                    idx_next   = '0;
                    state_next = S_LV_INIT;
                end
                else
                begin
                    depth_next = depth_reg - VIW'(1);
                    stack_re   = 1'b1;
                    stack_ra   = depth_reg - VIW'(1);
                    state_next = S_W_POP;
                end
            end
            S_W_POP:
            begin
                arc_next   = stack_q;
                dl_re      = 1'b1;
                dl_ra      = stack_q;
                state_next = S_W_POP2;
            end
            S_W_POP2:
            begin
                cur_next   = dl_link;
                dl_re      = 1'b1;
                dl_ra      = arc_reg ^ AIW'(1);
                state_next = S_W_POP3;
            end
            S_W_POP3:
            begin
                v_next     = VIW'(dl_dest);
                lvl_re     = 1'b1;
                lvl_ra     = VIW'(dl_dest);
                state_next = S_W_POP4;
            end
            S_W_POP4:
            begin
                vlev_next  = lvl_q;
                state_next = S_W_TOP;
            end
            S_BN_RD:
            begin
                if (k_reg == depth_reg)
                begin
                    total_next = flow_sum[FLOW_W] ? '1 : flow_sum[FLOW_W-1:0];
                    k_next     = '0;
                    state_next = S_UP_RD;
                end
                else
                begin
                    stack_re   = 1'b1;
                    stack_ra   = k_reg;
                    state_next = S_BN_S;
                end
            end
            S_BN_S:
            begin
                res_re     = 1'b1;
                res_ra     = stack_q;
                state_next = S_BN_R;
            end
            S_BN_R:
            begin
                if (res_q < b_reg)
                begin
                    b_next = res_q;
                end
                k_next     = k_reg + VIW'(1);
                state_next = S_BN_RD;
            end
            S_UP_RD:
            begin
                if (k_reg == depth_reg)
                begin
                    state_next = S_W_START;
                end
                else
                begin
                    stack_re   = 1'b1;
                    stack_ra   = k_reg;
                    state_next = S_UP_S;
                end
            end
            S_UP_S:
            begin
                arc_next   = stack_q;
                res_re     = 1'b1;
                res_ra     = stack_q;
                state_next = S_UP_A;
            end
            S_UP_A:
            begin
                res_we     = 1'b1;
                res_wa     = arc_reg;
                res_wd     = res_q - b_reg;
                res_re     = 1'b1;
                res_ra     = arc_reg ^ AIW'(1);
                state_next = S_UP_B;
            end
            S_UP_B:
            begin
                res_we     = 1'b1;
                res_wa     = arc_reg ^ AIW'(1);
                res_wd     = res_q + b_reg;
                k_next     = k_reg + VIW'(1);
                state_next = S_UP_RD;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            idx_reg       <= '0;
            pend_reg      <= 1'b0;
            arc_count_reg <= '0;
            total_reg     <= '0;
            status_reg    <= ST_OK;
            rd_reg        <= '0;
            wr_reg        <= '0;
            depth_reg     <= '0;
            k_reg         <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            pend_reg      <= pend_next;
            arc_count_reg <= arc_count_next;
            total_reg     <= total_next;
            status_reg    <= status_next;
            rd_reg        <= rd_next;
            wr_reg        <= wr_next;
            depth_reg     <= depth_next;
            k_reg         <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        v_reg    <= v_next;
        d_reg    <= d_next;
        cur_reg  <= cur_next;
        vlev_reg <= vlev_next;
        arc_reg  <= arc_next;
        b_reg    <= b_next;
    end

    assign stat.ready      = (state_reg == S_IDLE);
    assign stat.done       = (state_reg == S_DONE);
    assign result.max_flow = total_reg;
    assign result.status   = status_reg;

    // arcs are always pushed in forward/reverse pairs
    assert property (@(posedge clk) disable iff (!rst_n) arc_count_reg[0] == 1'b0)
        else $error("arc count odd");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_BQ) |-> (wr_reg <= n_eff && rd_reg <= wr_reg))
        else $error("level search queue pointers out of order");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |=> (total_reg >= $past(total_reg)))
        else $error("flow total went down during a solve");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_W_TOP) |-> (32'(depth_reg) < 32'(n_eff)))
        else $error("path stack deeper than vertex count");

endmodule
`default_nettype wire
